@@ design/linear_probe_hash_table_macros.svh @@
// assertion macros used by the linear probe hash table datapath
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition must never hold
`define LPHT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ design/lpht_pkg.sv @@
// shared types and constants of the linear probe hash table
package lpht_pkg;

  localparam int unsigned CAPACITY = 1024;  // power of two
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned WORD_W   = 1 + KEY_W + VAL_W;

  localparam logic [63:0]       HASH_MULT = 64'd2654435761;
  localparam logic [SLOT_W-1:0] HASH_LO   = HASH_MULT[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_STORE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } lpht_state_e;

  typedef struct packed {
    logic clear_step;  // write an empty word at the sweep index
    logic load;        // capture the input item and its home slot
    logic rd_next;     // read the slot after the current one
    logic advance;     // step to the next slot
    logic finish;      // commit the store and load the result register
  } lpht_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic probe_end;
    logic out_free;
  } lpht_stat_t;

  // low product bits give the residue for a power-of-two capacity
  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [2*SLOT_W-1:0] prod;
    prod = {{SLOT_W{1'b0}}, key[SLOT_W-1:0]} * {{SLOT_W{1'b0}}, HASH_LO};
    return prod[SLOT_W-1:0];
  endfunction

endpackage

@@ design/lpht_ctrl.sv @@
// controller state machine of the linear probe hash table
module lpht_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lpht_pkg::lpht_stat_t   stat_i,
  output lpht_pkg::lpht_cmd_t    cmd_o
);

  lpht_pkg::lpht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        if (stat_i.clear_last) state_d = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_PROBE: begin
        state_d = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        if (stat_i.probe_end && stat_i.out_free) state_d = lpht_pkg::ST_IDLE;
      end
      default: state_d = lpht_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      lpht_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lpht_pkg::ST_PROBE: begin
        cmd_o.rd_next = 1'b0;
      end
      lpht_pkg::ST_CHECK: begin
        if (!stat_i.probe_end) begin
          // read ahead so the next slot's word is ready as the index steps to it
          cmd_o.advance = 1'b1;
          cmd_o.rd_next = 1'b1;
        end else begin
          // while the result waits, keep rereading the current slot
          cmd_o.finish = stat_i.out_free;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ design/lpht_dp.sv @@
// datapath of the linear probe hash table: slot memory, probe index, result register
`include "linear_probe_hash_table_macros.svh"

module lpht_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpht_pkg::lpht_cmd_t           cmd_i,
  output lpht_pkg::lpht_stat_t          stat_o,
  input  logic                          action_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpht_pkg::VAL_W-1:0]    read_value_o,
  output logic                          found_o,
  output logic                          table_full_o
);

  localparam int unsigned SW = lpht_pkg::SLOT_W;
  localparam int unsigned KW = lpht_pkg::KEY_W;
  localparam int unsigned VW = lpht_pkg::VAL_W;
  localparam int unsigned WW = lpht_pkg::WORD_W;

  // word layout: valid mark, key, value
  logic [WW-1:0] mem_q [lpht_pkg::CAPACITY];
  logic [WW-1:0] rd_q;

  logic          action_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] value_q;
  logic [SW-1:0] idx_q;
  logic [SW-1:0] cnt_q;

  logic          out_valid_q;
  logic [VW-1:0] read_value_q;
  logic          found_q;
  logic          full_q;

  logic [SW-1:0] idx_next;
  logic [SW-1:0] rd_addr;
  logic          slot_used;
  logic          slot_match;
  logic          slot_empty;
  logic          last_probe;
  logic          wr_en;
  logic [WW-1:0] wr_data;

  assign idx_next   = (idx_q == lpht_pkg::SLOT_LAST) ? '0 : idx_q + 1'b1;
  assign rd_addr    = cmd_i.rd_next ? idx_next : idx_q;
  assign slot_used  = rd_q[WW-1];
  assign slot_match = slot_used && (rd_q[WW-2 -: KW] == key_q);
  assign slot_empty = !slot_used;
  assign last_probe = (cnt_q == lpht_pkg::SLOT_LAST);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (cmd_i.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.finish && action_q == lpht_pkg::ACT_STORE &&
                 (slot_empty || slot_match)) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, key_q, value_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[idx_q] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      key_q    <= key_i;
      value_q  <= value_i;
      cnt_q    <= '0;
    end else if (cmd_i.advance) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // index doubles as the sweep counter of the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clear_step || cmd_i.advance) begin
      idx_q <= idx_next;
    end else if (cmd_i.load) begin
      idx_q <= lpht_pkg::home_slot(key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      read_value_q <= (action_q == lpht_pkg::ACT_LOOKUP && slot_match) ?
                      rd_q[VW-1:0] : '0;
      found_q      <= slot_match;
      full_q       <= !slot_empty && !slot_match;
    end
  end

  assign stat_o.clear_last = (idx_q == lpht_pkg::SLOT_LAST);
  assign stat_o.probe_end  = slot_empty || slot_match || last_probe;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign found_o      = found_q;
  assign table_full_o = full_q;

  `LPHT_ASSERT_IMP(a_finish_at_probe_end, cmd_i.finish, stat_o.probe_end)
  `LPHT_ASSERT_IMP(a_finish_needs_free_out, cmd_i.finish, stat_o.out_free)
  `LPHT_ASSERT_IMP(a_no_step_past_last, cmd_i.advance, !last_probe)
  `LPHT_ASSERT_NEVER(a_found_and_full, out_valid_q && found_q && full_q)

endmodule

@@ design/linear_probe_hash_table.sv @@
// top level of the linear probe hash table: controller and datapath
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_ready_o   action_i, key_i, value_i
//   result    out        out_valid_o/out_ready_i read_value_o, found_o, table_full_o
//
// an item is captured in ST_IDLE, reads its home slot in ST_PROBE, then probes 1 to CAPACITY
//   slots in ST_CHECK; the controller is back in ST_IDLE as the result is loaded
// one probe per cycle, set by the single registered read port of the slot memory
// after reset a clearing pass writes one slot per cycle over all CAPACITY (1024) slots,
//   with in_ready_o low
// a result waiting on out_ready_i holds the next item in its last probe cycle
// in_ready_o is high only while no item is in flight
module linear_probe_hash_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpht_pkg::VAL_W-1:0]    read_value_o,
  output logic                          found_o,
  output logic                          table_full_o
);

  lpht_pkg::lpht_cmd_t  cmd;
  lpht_pkg::lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lpht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .found_o      (found_o),
    .table_full_o (table_full_o)
  );

endmodule
